/* sv/bsps_pkg.sv */
// shared types, constants and microcode table of the buffer stride padding search
package bsps_pkg;

   localparam int DEF_MAX_PAD_BYTES = 8192;
   localparam int DEF_MAX_LANES     = 64;

   localparam int COUNT_W  = 24;
   localparam int BYTE_W   = 14;
   localparam int LANE_W   = 7;
   localparam int STRIDE_W = 25;
   localparam int ALIGN_W  = 8;

   localparam int CRIT_STRIDE = 16 * 1024;
   localparam int CRIT_RANGE  = 768;

   typedef enum logic [2:0] {
      COND_ALWAYS,
      COND_REQ_VALID,
      COND_MISALIGNED,
      COND_NO_HOPS,
      COND_DIST_BAD,
      COND_LAST_HOP,
      COND_PAD_DONE,
      COND_SLOT_BUSY
   } cond_type;

   typedef enum logic [3:0] {
      STEP_WAIT,
      STEP_INIT,
      STEP_ALIGN,
      STEP_RULE,
      STEP_HOP,
      STEP_HOPEND,
      STEP_NEXT,
      STEP_PASS,
      STEP_FAIL
   } step_type;

   typedef struct packed {
      cond_type cond;
      step_type jump_t;
      step_type jump_f;
      logic     ld_req;
      logic     init;
      logic     ld_dist;
      logic     step_hop;
      logic     step_stride;
      logic     emit;
      logic     emit_found;
   } ucode_type;

   typedef struct packed {
      logic req_valid;
      logic misaligned;
      logic no_hops;
      logic dist_bad;
      logic last_hop;
      logic pad_done;
      logic slot_busy;
   } stat_type;

   typedef struct packed {
      logic req_ready;
      logic ld_req;
      logic init;
      logic ld_dist;
      logic step_hop;
      logic step_stride;
      logic emit;
      logic emit_found;
   } ctrl_type;

   function automatic ucode_type ucode_rom(step_type s);
      ucode_type w;
      w = '{cond: COND_ALWAYS, jump_t: STEP_WAIT, jump_f: STEP_WAIT, default: 1'b0};
      unique case (s)
         STEP_WAIT: begin
            w.cond = COND_REQ_VALID; w.jump_t = STEP_INIT; w.jump_f = STEP_WAIT;
            w.ld_req = 1'b1;
         end
         STEP_INIT: begin
            w.cond = COND_ALWAYS; w.jump_t = STEP_ALIGN; w.jump_f = STEP_ALIGN;
            w.init = 1'b1;
         end
         STEP_ALIGN: begin
            w.cond = COND_MISALIGNED; w.jump_t = STEP_NEXT; w.jump_f = STEP_RULE;
            w.ld_dist = 1'b1;
         end
         STEP_RULE: begin
            w.cond = COND_NO_HOPS; w.jump_t = STEP_PASS; w.jump_f = STEP_HOP;
         end
         STEP_HOP: begin
            w.cond = COND_DIST_BAD; w.jump_t = STEP_NEXT; w.jump_f = STEP_HOPEND;
         end
         STEP_HOPEND: begin
            w.cond = COND_LAST_HOP; w.jump_t = STEP_PASS; w.jump_f = STEP_HOP;
            w.step_hop = 1'b1;
         end
         STEP_NEXT: begin
            w.cond = COND_PAD_DONE; w.jump_t = STEP_FAIL; w.jump_f = STEP_ALIGN;
            w.step_stride = 1'b1;
         end
         STEP_PASS: begin
            w.cond = COND_SLOT_BUSY; w.jump_t = STEP_PASS; w.jump_f = STEP_WAIT;
            w.emit = 1'b1; w.emit_found = 1'b1;
         end
         STEP_FAIL: begin
            w.cond = COND_SLOT_BUSY; w.jump_t = STEP_FAIL; w.jump_f = STEP_WAIT;
            w.emit = 1'b1;
         end
         default: begin
            w.cond = COND_ALWAYS; w.jump_t = STEP_WAIT; w.jump_f = STEP_WAIT;
         end
      endcase
      return w;
   endfunction

endpackage

/* sv/bsps_ucode_seq.sv */
// step counter and microcode sequencer of the stride search
module bsps_ucode_seq (
   input  logic              clock,
   input  logic              reset,
   input  bsps_pkg::stat_type stat,
   output bsps_pkg::ctrl_type ctrl
);

   bsps_pkg::step_type  step_ff;
   bsps_pkg::step_type  step_in;
   bsps_pkg::ucode_type word;
   logic                taken;

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= bsps_pkg::STEP_WAIT;
      end else begin
         step_ff <= step_in;
      end
   end

   always_comb begin
      word = bsps_pkg::ucode_rom(step_ff);
      unique case (word.cond)
         bsps_pkg::COND_ALWAYS:     taken = 1'b1;
         bsps_pkg::COND_REQ_VALID:  taken = stat.req_valid;
         bsps_pkg::COND_MISALIGNED: taken = stat.misaligned;
         bsps_pkg::COND_NO_HOPS:    taken = stat.no_hops;
         bsps_pkg::COND_DIST_BAD:   taken = stat.dist_bad;
         bsps_pkg::COND_LAST_HOP:   taken = stat.last_hop;
         bsps_pkg::COND_PAD_DONE:   taken = stat.pad_done;
         bsps_pkg::COND_SLOT_BUSY:  taken = stat.slot_busy;
         default:                   taken = 1'b0;
      endcase
      step_in = taken ? word.jump_t : word.jump_f;

      ctrl.req_ready   = (step_ff == bsps_pkg::STEP_WAIT);
      ctrl.ld_req      = word.ld_req;
      ctrl.init        = word.init;
      ctrl.ld_dist     = word.ld_dist;
      ctrl.step_hop    = word.step_hop;
      ctrl.step_stride = word.step_stride;
      ctrl.emit        = word.emit & ~stat.slot_busy;
      ctrl.emit_found  = word.emit_found;
   end

endmodule

/* sv/buffer_stride_padding_search.sv */
// top level of the buffer stride padding search: datapath and result register
//
//  channel | direction | ports
//  --------+-----------+-----------------------------------------------------------
//  req     | in        | req_valid, req_ready, req_element_count, req_element_bytes,
//          |           | req_lane_total
//  rsp     | out       | rsp_valid, rsp_ready, rsp_chosen_stride, rsp_found
//  csr     | in        | csr_we, csr_wdata (stride_rule)
//
// one item at a time: setup and emit, plus, per candidate stride, an alignment
// step, a rule step when it passes alignment (skipped when misaligned), and a
// check per hop unless hops are skipped (hop loop of the microcode, up to lanes-1 hops)
// candidates number up to MAX_PAD_BYTES / element_bytes + 1
// synchronous reset clears the step counter, result valid and stride_rule
// a waiting result holds the sequencer in its emit step; req_ready is high only when idle
module buffer_stride_padding_search #(
   parameter int MAX_PAD_BYTES = bsps_pkg::DEF_MAX_PAD_BYTES,
   parameter int MAX_LANES     = bsps_pkg::DEF_MAX_LANES
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [bsps_pkg::COUNT_W-1:0]  req_element_count,
   input  logic [bsps_pkg::BYTE_W-1:0]   req_element_bytes,
   input  logic [bsps_pkg::LANE_W-1:0]   req_lane_total,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [bsps_pkg::STRIDE_W-1:0] rsp_chosen_stride,
   output logic                          rsp_found,
   input  logic                          csr_we,
   input  logic                          csr_wdata
);

   localparam int PAD_W = $clog2(MAX_PAD_BYTES + 2 ** bsps_pkg::BYTE_W);

   bsps_pkg::stat_type stat;
   bsps_pkg::ctrl_type ctrl;

   logic                            rule_ff;
   logic [bsps_pkg::COUNT_W-1:0]    count_ff;
   logic [bsps_pkg::BYTE_W-1:0]     size_ff;
   logic [bsps_pkg::LANE_W-1:0]     lanes_ff;
   logic [bsps_pkg::LANE_W-1:0]     lanes_in;
   logic [bsps_pkg::STRIDE_W-1:0]   stride_ff;
   logic [bsps_pkg::BYTE_W-1:0]     bytes_ff;
   logic [bsps_pkg::BYTE_W-1:0]     dist_ff;
   logic [bsps_pkg::LANE_W-1:0]     hop_ff;
   logic [PAD_W-1:0]                pad_ff;
   logic [PAD_W-1:0]                pad_sum;
   logic [2*bsps_pkg::BYTE_W-1:0]   prod;
   logic                            rsp_valid_ff;
   logic [bsps_pkg::STRIDE_W-1:0]   rsp_stride_ff;
   logic                            rsp_found_ff;

   bsps_ucode_seq u_seq (
      .clock (clock),
      .reset (reset),
      .stat  (stat),
      .ctrl  (ctrl)
   );

   always_comb begin
      if (32'(req_lane_total) > MAX_LANES) begin
         lanes_in = bsps_pkg::LANE_W'(MAX_LANES);
      end else begin
         lanes_in = req_lane_total;
      end
      prod    = count_ff[bsps_pkg::BYTE_W-1:0] * size_ff;
      pad_sum = pad_ff + PAD_W'(size_ff);

      stat.req_valid  = req_valid;
      stat.misaligned = (bytes_ff[bsps_pkg::ALIGN_W-1:0] != '0);
      stat.no_hops    = ~rule_ff | (lanes_ff <= bsps_pkg::LANE_W'(1));
      stat.dist_bad   =
         (dist_ff >= bsps_pkg::BYTE_W'(bsps_pkg::CRIT_STRIDE - bsps_pkg::CRIT_RANGE)) ||
         (dist_ff <= bsps_pkg::BYTE_W'(bsps_pkg::CRIT_RANGE));
      stat.last_hop   = ({1'b0, hop_ff} + 1'b1) >= {1'b0, lanes_ff};
      stat.pad_done   = (size_ff == '0) || (pad_sum > PAD_W'(MAX_PAD_BYTES));
      stat.slot_busy  = rsp_valid_ff & ~rsp_ready;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rule_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            rule_ff <= csr_wdata;
         end
         if (ctrl.emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.ld_req) begin
         count_ff <= req_element_count;
         size_ff  <= req_element_bytes;
         lanes_ff <= lanes_in;
      end
      if (ctrl.init) begin
         stride_ff <= {1'b0, count_ff};
         bytes_ff  <= prod[bsps_pkg::BYTE_W-1:0];
         pad_ff    <= '0;
      end
      if (ctrl.step_stride) begin
         stride_ff <= stride_ff + 1'b1;
         bytes_ff  <= bytes_ff + size_ff;
         pad_ff    <= pad_sum;
      end
      if (ctrl.ld_dist) begin
         dist_ff <= bytes_ff;
         hop_ff  <= bsps_pkg::LANE_W'(1);
      end
      if (ctrl.step_hop) begin
         dist_ff <= dist_ff + bytes_ff;
         hop_ff  <= hop_ff + 1'b1;
      end
      if (ctrl.emit) begin
         rsp_found_ff  <= ctrl.emit_found;
         rsp_stride_ff <= ctrl.emit_found ? stride_ff : '0;
      end
   end

   assign req_ready         = ctrl.req_ready;
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_chosen_stride = rsp_stride_ff;
   assign rsp_found         = rsp_found_ff;

endmodule
